FILE: rtl/skf_pkg.sv
// Package for the scalar Kalman filter: widths, fixed-point constants,
// register indexes, sequencer states and payload structs.
// No dependencies.
`default_nettype none

package skf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Radix-2 restoring divider, two quotient bits per cycle
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES         = DATA_WIDTH / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_MEAN     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VARIANCE = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_VARIANCE  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_VARIANCE  = CFG_INDEX_W'(3);

  localparam logic [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] SMAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SMIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIFF,
    ST_MUL_K,
    ST_LOAD_K,
    ST_DIV_K,
    ST_MUL_V,
    ST_LOAD_V,
    ST_DIV_V,
    ST_FIN
  } skf_state_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] move_distance;
    logic signed [DATA_WIDTH-1:0] measured_position;
    logic                         restart;
  } skf_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] estimate_mean;
    logic        [DATA_WIDTH-1:0] estimate_variance;
    logic                         saturated;
  } skf_out_t;

endpackage

`default_nettype wire

FILE: rtl/scalar_kalman_filter.sv
// Scalar Kalman filter: one predict and one correct step per transaction.
// A new transaction is taken only in the idle state, so one is finished and its
// result handed to the output register before the next is accepted.
// The shared 32x32 multiplier and the two-bit-per-cycle divider each run twice
// per transaction, among the prep, diff, load and finish steps.
// Reset (rst, synchronous): configuration registers go to their defaults,
// estimate to mean 0 / variance 1.0, sequencer idle, no result pending.
`default_nettype none

module scalar_kalman_filter (
  input  wire                                 clk,
  input  wire                                 rst,
  // input channel
  input  wire                                 item_valid,
  output logic                                item_stall,
  input  wire  skf_pkg::skf_in_t              item,
  // result channel
  output logic                                result_valid,
  input  wire                                 result_stall,
  output skf_pkg::skf_out_t                   result,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [skf_pkg::DATA_WIDTH-1:0]      cfg_data
);

  localparam int DW = skf_pkg::DATA_WIDTH;

  // Configuration registers
  logic [DW-1:0] init_mean;
  logic [DW-1:0] init_var;
  logic [DW-1:0] sensor_var;
  logic [DW-1:0] motion_var;

  // Filter state carried between transactions
  logic [DW-1:0] est_mean;
  logic [DW-1:0] est_var;

  // Sequencer
  skf_pkg::skf_state_t state, state_next;
  logic [skf_pkg::DIV_CNT_W-1:0] div_cnt;
  logic div_last;
  logic fin_load;

  // Latched transaction and working registers
  skf_pkg::skf_in_t item_q;
  logic [DW-1:0]   mp;        // predicted mean
  logic [DW-1:0]   vp;        // predicted variance
  logic            sat;
  logic [DW:0]     d;         // vp + vs, exact
  logic            neg;       // measurement below predicted mean
  logic [DW-1:0]   mag;       // |z - mp|
  logic [2*DW-1:0] prod;      // shared multiplier output
  logic [DW:0]     rem;       // divider partial remainder
  logic [DW-1:0]   quo;       // dividend bits shifting out, quotient shifting in
  logic [DW-1:0]   kq;        // mean correction magnitude

  // Combinational helpers
  logic [DW-1:0]   mean_src;
  logic [DW-1:0]   var_src;
  logic [DW:0]     mean_sum;
  logic [DW:0]     var_sum;
  logic [DW:0]     diff;
  logic [DW-1:0]   mul_b;
  logic [2*DW:0]   num;
  logic [DW:0]     rem_w;
  logic [DW-1:0]   quo_w;
  logic [DW+1:0]   trial;
  logic [DW:0]     mean_new;
  logic [DW-1:0]   k_eff;
  logic [DW-1:0]   var_eff;
  logic            dzero;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the last register drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      init_mean  <= '0;
      init_var   <= skf_pkg::ONE_Q;
      sensor_var <= skf_pkg::ONE_Q;
      motion_var <= skf_pkg::ONE_Q;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        skf_pkg::REG_INITIAL_MEAN:     init_mean  <= cfg_data;
        skf_pkg::REG_INITIAL_VARIANCE: init_var   <= cfg_data;
        skf_pkg::REG_SENSOR_VARIANCE:  sensor_var <= cfg_data;
        skf_pkg::REG_MOTION_VARIANCE:  motion_var <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: state register and next-state logic
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign div_last = (div_cnt == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_CYCLES - 1));

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    fin_load   = 1'b0;
    case (state)
      skf_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) state_next = skf_pkg::ST_PREP;
      end
      skf_pkg::ST_PREP:   state_next = skf_pkg::ST_DIFF;
      skf_pkg::ST_DIFF:   state_next = skf_pkg::ST_MUL_K;
      skf_pkg::ST_MUL_K:  state_next = skf_pkg::ST_LOAD_K;
      skf_pkg::ST_LOAD_K: state_next = skf_pkg::ST_DIV_K;
      skf_pkg::ST_DIV_K: begin
        if (div_last) state_next = skf_pkg::ST_MUL_V;
      end
      skf_pkg::ST_MUL_V:  state_next = skf_pkg::ST_LOAD_V;
      skf_pkg::ST_LOAD_V: state_next = skf_pkg::ST_DIV_V;
      skf_pkg::ST_DIV_V: begin
        if (div_last) state_next = skf_pkg::ST_FIN;
      end
      skf_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!result_valid || !result_stall) begin
          fin_load   = 1'b1;
          state_next = skf_pkg::ST_IDLE;
        end
      end
      default: state_next = skf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == skf_pkg::ST_DIV_K || state == skf_pkg::ST_DIV_V) begin
      div_cnt <= div_cnt + skf_pkg::DIV_CNT_W'(1);
    end else begin
      div_cnt <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Predict: restart picks the initial registers, then add with clipping
  // ---------------------------------------------------------------------
  assign mean_src = item_q.restart ? init_mean : est_mean;
  assign var_src  = item_q.restart ? init_var  : est_var;
  assign mean_sum = {mean_src[DW-1], mean_src}
                  + {item_q.move_distance[DW-1], item_q.move_distance};
  assign var_sum  = {1'b0, var_src} + {1'b0, motion_var};

  // Correct: signed innovation and total variance
  assign diff = {item_q.measured_position[DW-1], item_q.measured_position}
              - {mp[DW-1], mp};

  // Shared multiplier: vp * |z - mp| first, then vp * vs
  assign mul_b = (state == skf_pkg::ST_MUL_K) ? mag : sensor_var;

  // Round half up: add d/2 before dividing
  assign num = {1'b0, prod} + {{(DW+1){1'b0}}, d[DW:1]};

  // Two restoring-division steps per cycle
  always_comb begin
    rem_w = rem;
    quo_w = quo;
    trial = '0;
    for (int i = 0; i < skf_pkg::DIV_BITS_PER_CYCLE; i++) begin
      trial = {rem_w, quo_w[DW-1]};
      quo_w = {quo_w[DW-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial    = trial - {1'b0, d};
        quo_w[0] = 1'b1;
      end
      rem_w = trial[DW:0];
    end
  end

  // With both variances zero the mean stays put and the variance is zero
  assign dzero    = (d == '0);
  assign k_eff    = dzero ? '0 : kq;
  assign var_eff  = dzero ? '0 : quo;
  assign mean_new = neg ? ({mp[DW-1], mp} - {1'b0, k_eff})
                        : ({mp[DW-1], mp} + {1'b0, k_eff});

  always_ff @(posedge clk) begin
    case (state)
      skf_pkg::ST_IDLE: begin
        if (item_valid) item_q <= item;
      end
      skf_pkg::ST_PREP: begin
        sat <= 1'b0;
        if (mean_sum[DW] != mean_sum[DW-1]) begin
          mp  <= mean_sum[DW] ? skf_pkg::SMIN : skf_pkg::SMAX;
          sat <= 1'b1;
        end else begin
          mp <= mean_sum[DW-1:0];
        end
        if (var_sum[DW]) begin
          vp  <= '1;
          sat <= 1'b1;
        end else begin
          vp <= var_sum[DW-1:0];
        end
      end
      skf_pkg::ST_DIFF: begin
        d   <= {1'b0, vp} + {1'b0, sensor_var};
        neg <= diff[DW];
        mag <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
      end
      skf_pkg::ST_MUL_K, skf_pkg::ST_MUL_V: begin
        prod <= (2*DW)'(vp) * (2*DW)'(mul_b);
        if (state == skf_pkg::ST_MUL_V) kq <= quo;
      end
      skf_pkg::ST_LOAD_K, skf_pkg::ST_LOAD_V: begin
        // quotient fits DW bits, so the upper part starts below d
        rem <= num[2*DW:DW];
        quo <= num[DW-1:0];
      end
      skf_pkg::ST_DIV_K, skf_pkg::ST_DIV_V: begin
        rem <= rem_w;
        quo <= quo_w;
      end
      default: ;
    endcase
  end

  // Estimate state: advance when the result leaves the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      est_mean <= '0;
      est_var  <= skf_pkg::ONE_Q;
    end else if (fin_load) begin
      est_mean <= mean_new[DW-1:0];
      est_var  <= var_eff;
    end
  end

  // Output register: parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      result.estimate_mean     <= mean_new[DW-1:0];
      result.estimate_variance <= var_eff;
      result.saturated         <= sat;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/skf_checker.sv
// Port-level checker for the scalar Kalman filter, bound to the top level.
// Depends on skf_pkg.
`default_nettype none

module skf_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             item_valid,
  input wire                             item_stall,
  input wire                             result_valid,
  input wire                             result_stall,
  input wire skf_pkg::skf_out_t          result
);

  // An accepted transaction keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input not stalled after acceptance");

  // A result never appears in the cycle right after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !$rose(result_valid))
    else $error("result appeared too early");

  // A new result only follows a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result without a transaction in flight");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);

`default_nettype wire
